>>> rtl/bf16_add_sub_mul_fma_unit_macros.svh
// ----------------------------------------------------------------------------
// bf16_add_sub_mul_fma_unit_macros.svh
// Assertion macros shared by the bfloat16 arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef BF16_ADD_SUB_MUL_FMA_UNIT_MACROS_SVH
`define BF16_ADD_SUB_MUL_FMA_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BFU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define BFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bfu_pkg.sv
// ----------------------------------------------------------------------------
// bfu_pkg
// Shared types and constants for the bfloat16 arithmetic unit.
// ----------------------------------------------------------------------------
package bfu_pkg;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_FMA = 2'd3;

    localparam logic [1:0] RM_RNE = 2'd0;
    localparam logic [1:0] RM_RTZ = 2'd1;
    localparam logic [1:0] RM_RDN = 2'd2;
    localparam logic [1:0] RM_RUP = 2'd3;

    localparam logic [15:0] QNAN_CANON = 16'h7FC0;

    // Working magnitude: the 16-bit significand field sits above 24 lower bits, the
    // lowest of them sticky. The exact sum is formed at this width with a sticky OR.
    localparam int MagW = 40;

    // Result of the front end: either a finished special value or a finite
    // sum that still needs normalization and rounding.
    typedef struct packed {
        logic        special;
        logic [15:0] spec_val;
        logic        spec_inv;
        logic        zero_res;
        logic        neg;
        logic signed [10:0] lsb_exp;
        logic [MagW-1:0] mag;
        logic [1:0]  mode;
    } bfu_sum_t;

endpackage

>>> rtl/bfu_round.sv
// ----------------------------------------------------------------------------
// bfu_round
// Normalizes a finite magnitude and rounds it to bfloat16, two stages.
// ----------------------------------------------------------------------------
module bfu_round
    import bfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  bfu_sum_t    sum,
    output logic        out_valid,
    output logic [15:0] result,
    output logic        flag_invalid,
    output logic        flag_overflow,
    output logic        flag_underflow,
    output logic        flag_inexact
);

    // Stage one: leading-one position and normalizing shift.
    logic [5:0]  len;
    logic signed [11:0] q_raw, q_cl, s_amt;
    logic [MagW+8:0] ext;
    logic [8:0]  sig_n;
    logic        rb_n, st_n;
    logic [MagW+8:0] sh;
    logic [MagW+8:0] mask;
    logic [5:0]  rsh;

    always_comb
    begin
        len = '0;
        for (int i = 0; i < MagW; i++)
        begin
            if (sum.mag[i])
                len = 6'(i + 1);
        end
        q_raw = 12'(sum.lsb_exp) + 12'(len) - 12'sd8;
        q_cl  = (q_raw < -12'sd133) ? -12'sd133 : q_raw;
        s_amt = q_cl - 12'(sum.lsb_exp);
        ext   = {9'd0, sum.mag};
        sig_n = '0;
        rb_n  = 1'b0;
        st_n  = 1'b0;
        sh    = '0;
        mask  = '0;
        rsh   = '0;
        if (s_amt <= 0)
        begin
            sh    = ext << 6'(-s_amt);
            sig_n = {1'b0, sh[7:0]};
        end
        else
        begin
            // A tiny value may put the round position far above the window;
            // past the window top every bit is sticky.
            if (s_amt > 12'(MagW + 9))
                rsh = 6'(MagW + 9);
            else
                rsh = 6'(s_amt - 12'sd1);
            sh    = ext >> rsh;
            sig_n = {1'b0, sh[8:1]};
            rb_n  = sh[0];
            mask  = ~({(MagW+9){1'b1}} << rsh);
            st_n  = |(ext & mask);
        end
    end

    logic        v1_reg;
    bfu_sum_t    s1_reg;
    logic [7:0]  sig_reg;
    logic signed [11:0] q_reg;
    logic        rb_reg, st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= sum;
            sig_reg <= sig_n[7:0];
            q_reg   <= q_cl;
            rb_reg  <= rb_n;
            st_reg  <= st_n;
        end
    end

    // Stage two: round, pack and flag.
    logic [15:0] res_next;
    logic        inv_next, ovf_next, unf_next, inx_next;
    logic        inc, inx;
    logic [8:0]  sg;
    logic signed [11:0] q2, field;
    logic        fin;
    logic [15:0] sign;

    always_comb
    begin
        sign = {s1_reg.neg, 15'd0};
        inx  = rb_reg | st_reg;
        inc  = 1'b0;
        case (s1_reg.mode)
            RM_RNE:  inc = rb_reg & (st_reg | sig_reg[0]);
            RM_RTZ:  inc = 1'b0;
            RM_RDN:  inc = inx & s1_reg.neg;
            RM_RUP:  inc = inx & ~s1_reg.neg;
            default: inc = 1'b0;
        endcase
        sg = {1'b0, sig_reg} + {8'd0, inc};
        q2 = q_reg;
        if (sg[8])
        begin
            sg = sg >> 1;
            q2 = q_reg + 12'sd1;
        end
        field = sg[7] ? q2 + 12'sd134 : 12'sd0;
        fin = (s1_reg.mode == RM_RTZ) || (s1_reg.neg && s1_reg.mode == RM_RUP)
            || (!s1_reg.neg && s1_reg.mode == RM_RDN);
        res_next = '0;
        inv_next = 1'b0;
        ovf_next = 1'b0;
        unf_next = 1'b0;
        inx_next = 1'b0;
        if (s1_reg.special)
        begin
            res_next = s1_reg.spec_val;
            inv_next = s1_reg.spec_inv;
        end
        else if (s1_reg.zero_res)
        begin
            res_next = sign;
        end
        else if (field >= 12'sd255)
        begin
            res_next = sign | (fin ? 16'h7F7F : 16'h7F80);
            ovf_next = 1'b1;
            inx_next = 1'b1;
        end
        else
        begin
            res_next = sign | {1'b0, field[7:0], sg[6:0]};
            inx_next = inx;
            unf_next = (field == 12'sd0) && inx;
        end
    end

    logic        v2_reg;
    logic [15:0] res_reg;
    logic        inv_reg, ovf_reg, unf_reg, inx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            inv_reg <= inv_next;
            ovf_reg <= ovf_next;
            unf_reg <= unf_next;
            inx_reg <= inx_next;
        end
    end

    assign out_valid      = v2_reg;
    assign result         = res_reg;
    assign flag_invalid   = inv_reg;
    assign flag_overflow  = ovf_reg;
    assign flag_underflow = unf_reg;
    assign flag_inexact   = inx_reg;

endmodule

>>> rtl/bf16_add_sub_mul_fma_unit.sv
// Pipeline: an accepted item passes the multiply, align/add, normalize and round
// stages in order to its result. Throughput: one item per cycle; a stall on the
// result side freezes the whole pipeline, so nothing is lost or repeated.
// Reset: rst_n clears all valid bits asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
// bf16_add_sub_mul_fma_unit
// Pipelined bfloat16 add, subtract, multiply and fused multiply-add.
// ----------------------------------------------------------------------------
`include "bf16_add_sub_mul_fma_unit_macros.svh"

module bf16_add_sub_mul_fma_unit
    import bfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [15:0] operand_c,
    input  logic [1:0]  round_mode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result,
    output logic        flag_invalid,
    output logic        flag_overflow,
    output logic        flag_underflow,
    output logic        flag_inexact
);

    // The whole pipeline advances together. The output register is the last
    // stage; it may be replaced whenever it is empty or being taken, so an
    // item is accepted even while older items are still in flight.
    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // ------------------------------------------------------------------
    // Stage one: classify operands, resolve specials, form the exact
    // 16-bit product of the significands.
    // ------------------------------------------------------------------
    function automatic logic is_nan(input logic [15:0] v);
        return (v[14:7] == 8'hFF) && (v[6:0] != 7'd0);
    endfunction
    function automatic logic is_inf(input logic [15:0] v);
        return v[14:0] == 15'h7F80;
    endfunction
    function automatic logic is_zero(input logic [15:0] v);
        return v[14:0] == 15'd0;
    endfunction
    function automatic logic is_snan(input logic [15:0] v);
        return is_nan(v) && !v[6];
    endfunction

    logic [15:0] b_eff;
    logic        special_n, spec_inv_n;
    logic [15:0] spec_val_n;
    logic        use_mul, fused, pn;
    logic [7:0]  sa, sb, sc;
    logic signed [9:0] la, lb, lc;

    always_comb
    begin
        use_mul = func[1];
        fused   = (func == FUNC_FMA);
        b_eff   = (func == FUNC_SUB) ? {~operand_b[15], operand_b[14:0]} : operand_b;
        pn      = operand_a[15] ^ operand_b[15];
        special_n  = 1'b1;
        spec_inv_n = 1'b0;
        spec_val_n = '0;
        if (!use_mul)
        begin
            if (is_nan(operand_a) || is_nan(operand_b))
            begin
                spec_inv_n = is_snan(operand_a) || is_snan(operand_b);
                spec_val_n = is_nan(operand_a) ? (operand_a | 16'h0040)
                                               : (operand_b | 16'h0040);
            end
            else if (is_inf(operand_a) && is_inf(b_eff) && operand_a[15] != b_eff[15])
            begin
                spec_val_n = QNAN_CANON;
                spec_inv_n = 1'b1;
            end
            else if (is_inf(operand_a))
                spec_val_n = operand_a;
            else if (is_inf(b_eff))
                spec_val_n = b_eff;
            else
                special_n = 1'b0;
        end
        else
        begin
            if (!fused && (is_nan(operand_a) || is_nan(operand_b)))
            begin
                spec_inv_n = is_snan(operand_a) || is_snan(operand_b);
                spec_val_n = is_nan(operand_a) ? (operand_a | 16'h0040)
                                               : (operand_b | 16'h0040);
            end
            else if ((is_inf(operand_a) && is_zero(operand_b))
                     || (is_zero(operand_a) && is_inf(operand_b)))
            begin
                spec_val_n = QNAN_CANON;
                spec_inv_n = 1'b1;
            end
            else if (fused && (is_nan(operand_a) || is_nan(operand_b)
                               || is_nan(operand_c)))
            begin
                spec_inv_n = is_snan(operand_a) || is_snan(operand_b)
                             || is_snan(operand_c);
                spec_val_n = is_nan(operand_a) ? (operand_a | 16'h0040) :
                             is_nan(operand_b) ? (operand_b | 16'h0040) :
                                                 (operand_c | 16'h0040);
            end
            else if (is_inf(operand_a) || is_inf(operand_b))
            begin
                if (fused && is_inf(operand_c) && operand_c[15] != pn)
                begin
                    spec_val_n = QNAN_CANON;
                    spec_inv_n = 1'b1;
                end
                else
                    spec_val_n = {pn, 15'h7F80};
            end
            else if (fused && is_inf(operand_c))
                spec_val_n = operand_c;
            else
                special_n = 1'b0;
        end
        sa = (operand_a[14:7] == 8'd0) ? {1'b0, operand_a[6:0]} : {1'b1, operand_a[6:0]};
        sb = (b_eff[14:7] == 8'd0) ? {1'b0, b_eff[6:0]} : {1'b1, b_eff[6:0]};
        sc = (operand_c[14:7] == 8'd0) ? {1'b0, operand_c[6:0]} : {1'b1, operand_c[6:0]};
        la = (operand_a[14:7] == 8'd0) ? -10'sd133 : 10'(operand_a[14:7]) - 10'sd134;
        lb = (b_eff[14:7] == 8'd0) ? -10'sd133 : 10'(b_eff[14:7]) - 10'sd134;
        lc = (operand_c[14:7] == 8'd0) ? -10'sd133 : 10'(operand_c[14:7]) - 10'sd134;
    end

    logic        v1_reg;
    logic        sp1_reg, spi1_reg;
    logic [15:0] spv1_reg;
    logic [1:0]  mode1_reg;
    logic        n1_reg, n2_reg, has2_reg;
    logic [15:0] s1_reg;
    logic [7:0]  s2_reg;
    logic signed [10:0] l1_reg, l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp1_reg   <= special_n;
            spi1_reg  <= spec_inv_n;
            spv1_reg  <= spec_val_n;
            mode1_reg <= round_mode;
            if (use_mul)
            begin
                n1_reg   <= pn;
                s1_reg   <= sa * sb;
                l1_reg   <= 11'(la) + 11'(lb);
                n2_reg   <= operand_c[15];
                s2_reg   <= fused ? sc : 8'd0;
                l2_reg   <= 11'(lc);
                has2_reg <= fused;
            end
            else
            begin
                n1_reg   <= operand_a[15];
                s1_reg   <= {8'd0, sa};
                l1_reg   <= 11'(la);
                n2_reg   <= b_eff[15];
                s2_reg   <= sb;
                l2_reg   <= 11'(lb);
                has2_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage two: align both terms on a 40-bit window and add or subtract.
    // The larger-exponent term sits at the top; bits of the smaller term
    // that fall below the window are folded into a sticky bit, which is
    // exact for rounding since the smaller term then lies far below. Once
    // the smaller term is entirely below the window, any larger distance
    // gives the same sticky bit, so the shift stops at the window width.
    // ------------------------------------------------------------------
    bfu_sum_t sum_next;
    logic        z1, z2, big1;
    logic signed [11:0] top1, top2, diff;
    logic [MagW-1:0] m_big, m_small, m_res;
    logic [MagW+15:0] wide_s;
    logic        stk, n_big, n_small;
    logic signed [10:0] l_big;
    logic [15:0] s_big, s_small;
    logic [5:0]  dsh;

    always_comb
    begin
        z1 = (s1_reg == 16'd0);
        z2 = (s2_reg == 8'd0);
        // Top bit position of each term (lsb + 16).
        top1 = 12'(l1_reg) + 12'sd16;
        top2 = 12'(l2_reg) + 12'sd16;
        big1 = z2 || (!z1 && top1 >= top2);
        s_big   = big1 ? s1_reg : {8'd0, s2_reg};
        s_small = big1 ? {8'd0, s2_reg} : s1_reg;
        n_big   = big1 ? n1_reg : n2_reg;
        n_small = big1 ? n2_reg : n1_reg;
        l_big   = big1 ? l1_reg : l2_reg;
        diff    = big1 ? (top1 - top2) : (top2 - top1);
        m_big   = {s_big, 24'd0};
        wide_s  = {s_small, 24'd0, 16'd0};
        dsh     = (diff > 12'sd40) ? 6'd40 : 6'(diff);
        wide_s  = wide_s >> dsh;
        m_small = wide_s[MagW+15:16];
        stk     = |wide_s[15:0];
        m_small[0] = m_small[0] | stk;
        if (z1 && z2)
            m_res = '0;
        else if (n_big == n_small || (big1 ? z2 : z1))
            m_res = m_big + m_small;
        else if (m_big >= m_small)
            m_res = m_big - m_small;
        else
            m_res = m_small - m_big;
        sum_next.special  = sp1_reg;
        sum_next.spec_val = spv1_reg;
        sum_next.spec_inv = spi1_reg;
        sum_next.mode     = mode1_reg;
        sum_next.mag      = m_res;
        sum_next.lsb_exp  = l_big - 11'sd24;
        sum_next.zero_res = (m_res == '0);
        if (z1 && z2)
            sum_next.neg = (!has2_reg || n1_reg == n2_reg) ? n1_reg
                                                            : (mode1_reg == RM_RDN);
        else if (m_res == '0)
            sum_next.neg = (mode1_reg == RM_RDN);
        else if (n_big == n_small || (big1 ? z2 : z1) || m_big >= m_small)
            sum_next.neg = n_big;
        else
            sum_next.neg = n_small;
    end

    logic     v2_reg;
    bfu_sum_t sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= sum_next;
    end

    // ------------------------------------------------------------------
    // Stages three and four: normalize, round and pack.
    // ------------------------------------------------------------------
    bfu_round u_round (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (v2_reg),
        .sum            (sum_reg),
        .out_valid      (out_valid),
        .result         (result),
        .flag_invalid   (flag_invalid),
        .flag_overflow  (flag_overflow),
        .flag_underflow (flag_underflow),
        .flag_inexact   (flag_inexact)
    );

    `BFU_ASSERT(a_stall_only_when_full, !in_stall || (out_valid && out_stall),
        "input stalled while output slot is free")
    `BFU_ASSERT(a_ovf_implies_inx, !out_valid || !flag_overflow || flag_inexact,
        "overflow without inexact")
    `BFU_ASSERT(a_unf_implies_inx, !out_valid || !flag_underflow || flag_inexact,
        "underflow without inexact")
    `BFU_ASSERT_NEXT(a_stage_hold, out_stall && out_valid, out_valid,
        "stalled result dropped")

endmodule

>>> sim/bf16_fma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_fma_checker
// Watches both channels of the bfloat16 arithmetic unit, computes the exact
// rounded result for every accepted item and compares it with the outputs.
// ----------------------------------------------------------------------------
module bf16_fma_checker
    import bfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [15:0] operand_c,
    input  logic [1:0]  round_mode,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] result,
    input  logic        flag_invalid,
    input  logic        flag_overflow,
    input  logic        flag_underflow,
    input  logic        flag_inexact,
    output int          mismatches,
    output int          results_owed
);

    // Exact magnitudes span from the smallest product bit up to the largest addend.
    localparam int W = 640;

    typedef struct packed {
        logic [15:0] value;
        logic        inv;
        logic        ovf;
        logic        unf;
        logic        inx;
    } bf_outcome_t;

    bf_outcome_t owed_results[$];

    function automatic bf_outcome_t plain_value(logic [15:0] v);
        return '{value: v, inv: 1'b0, ovf: 1'b0, unf: 1'b0, inx: 1'b0};
    endfunction

    function automatic bit is_nan(logic [15:0] v);
        return v[14:7] == 8'hFF && v[6:0] != 7'd0;
    endfunction

    function automatic bit is_inf(logic [15:0] v);
        return v[14:0] == 15'h7F80;
    endfunction

    function automatic bit is_zero(logic [15:0] v);
        return v[14:0] == 15'd0;
    endfunction

    function automatic bit is_snan(logic [15:0] v);
        return is_nan(v) && !v[6];
    endfunction

    // First NaN wins, quieted; any signaling NaN among the operands raises invalid.
    function automatic bf_outcome_t nan_pick(logic [15:0] a, logic [15:0] b,
                                             logic [15:0] c, bit use_c);
        bf_outcome_t o;
        o = plain_value(16'd0);
        o.inv = is_snan(a) || is_snan(b) || (use_c && is_snan(c));
        if (is_nan(a))
            o.value = a | 16'h0040;
        else if (is_nan(b))
            o.value = b | 16'h0040;
        else
            o.value = c | 16'h0040;
        return o;
    endfunction

    function automatic bf_outcome_t invalid_op();
        bf_outcome_t o;
        o = plain_value(QNAN_CANON);
        o.inv = 1'b1;
        return o;
    endfunction

    // Rounds the nonzero magnitude m * 2^lsb to bfloat16.
    function automatic bf_outcome_t round_exact(logic [W-1:0] m, int lsb, bit neg,
                                                logic [1:0] mode);
        bf_outcome_t o;
        int len, q, s, sig, field;
        bit rb, st, up, finite;
        logic [W-1:0] mask;
        o = plain_value(16'd0);
        len = 0;
        rb = 0;
        st = 0;
        up = 0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                len = i + 1;
                break;
            end
        end
        q = lsb + len - 1 - 7;
        if (q < -133)
            q = -133;
        s = q - lsb;
        if (s <= 0)
            sig = int'(m[15:0]) << (-s);
        else
        begin
            sig = 0;
            for (int i = 0; i < 8; i++)
                sig |= int'(m[s + i]) << i;
            rb = m[s - 1];
            mask = (W'(1) << (s - 1)) - W'(1);
            st = (m & mask) != '0;
        end
        o.inx = rb || st;
        if (o.inx)
        begin
            case (mode)
                RM_RNE: up = rb && (st || sig[0]);
                RM_RDN: up = neg;
                RM_RUP: up = !neg;
                default: up = 0;
            endcase
        end
        sig += up;
        if (sig >= 256)
        begin
            sig >>= 1;
            q++;
        end
        field = (sig >= 128) ? q + 134 : 0;
        if (field >= 255)
        begin
            finite = mode == RM_RTZ || (neg && mode == RM_RUP) || (!neg && mode == RM_RDN);
            o.value = {neg, finite ? 15'h7F7F : 15'h7F80};
            o.ovf = 1'b1;
            o.inx = 1'b1;
            return o;
        end
        o.value = {neg, field[7:0], sig[6:0]};
        o.unf = field == 0 && o.inx;
        return o;
    endfunction

    // Exact signed sum of two terms sig * 2^lsb, rounded once. A zero sig is a zero term.
    function automatic bf_outcome_t two_term_round(bit n1, int s1, int l1, bit n2, int s2,
                                                   int l2, logic [1:0] mode);
        logic [W-1:0] x, y;
        int base;
        bit tn;
        int tl;
        if (s1 == 0 && s2 == 0)
            return plain_value({(n1 == n2) ? n1 : (mode == RM_RDN), 15'd0});
        if (s1 == 0)
        begin
            tn = n1;
            tl = l1;
            n1 = n2;
            s1 = s2;
            l1 = l2;
            n2 = tn;
            s2 = 0;
            l2 = tl;
        end
        base = (s2 != 0 && l2 < l1) ? l2 : l1;
        x = W'(s1) << (l1 - base);
        y = (s2 != 0) ? (W'(s2) << (l2 - base)) : '0;
        if (s2 == 0 || n1 == n2)
            return round_exact(x + y, base, n1, mode);
        if (x == y)
            return plain_value({mode == RM_RDN, 15'd0});
        if (x > y)
            return round_exact(x - y, base, n1, mode);
        return round_exact(y - x, base, n2, mode);
    endfunction

    function automatic void split_operand(logic [15:0] v, output int sig, output int lsb);
        if (v[14:7] == 8'd0)
        begin
            sig = int'(v[6:0]);
            lsb = -133;
        end
        else
        begin
            sig = int'({1'b1, v[6:0]});
            lsb = int'(v[14:7]) - 134;
        end
    endfunction

    function automatic bf_outcome_t add_or_sub(logic [15:0] a, logic [15:0] b, bit sub,
                                               logic [1:0] mode);
        int sa, la, sb, lb;
        if (is_nan(a) || is_nan(b))
            return nan_pick(a, b, 16'd0, 0);
        if (sub)
            b[15] = !b[15];
        if (is_inf(a) || is_inf(b))
        begin
            if (is_inf(a) && is_inf(b) && a[15] != b[15])
                return invalid_op();
            return plain_value(is_inf(a) ? a : b);
        end
        split_operand(a, sa, la);
        split_operand(b, sb, lb);
        return two_term_round(a[15], sa, la, b[15], sb, lb, mode);
    endfunction

    function automatic bf_outcome_t mul_or_fma(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                               bit fused, logic [1:0] mode);
        bit pn;
        int sa, la, sb, lb, sc, lc;
        pn = a[15] ^ b[15];
        if (!fused && (is_nan(a) || is_nan(b)))
            return nan_pick(a, b, c, 0);
        // In the fused form infinity times zero outranks every NaN; a plain multiply checks NaNs first.
        if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
            return invalid_op();
        if (fused && (is_nan(a) || is_nan(b) || is_nan(c)))
            return nan_pick(a, b, c, 1);
        if (is_inf(a) || is_inf(b))
        begin
            if (fused && is_inf(c) && c[15] != pn)
                return invalid_op();
            return plain_value({pn, 15'h7F80});
        end
        if (fused && is_inf(c))
            return plain_value(c);
        split_operand(a, sa, la);
        split_operand(b, sb, lb);
        if (!fused)
            return two_term_round(pn, sa * sb, la + lb, pn, 0, la + lb, mode);
        split_operand(c, sc, lc);
        return two_term_round(pn, sa * sb, la + lb, c[15], sc, lc, mode);
    endfunction

    function automatic bf_outcome_t bf16_compute(logic [1:0] op, logic [15:0] a,
                                                 logic [15:0] b, logic [15:0] c,
                                                 logic [1:0] mode);
        case (op)
            FUNC_ADD: return add_or_sub(a, b, 0, mode);
            FUNC_SUB: return add_or_sub(a, b, 1, mode);
            FUNC_MUL: return mul_or_fma(a, b, c, 0, mode);
            default:  return mul_or_fma(a, b, c, 1, mode);
        endcase
    endfunction

    initial mismatches = 0;
    assign results_owed = owed_results.size();

    always @(posedge clk)
    begin
        bf_outcome_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                owed_results.push_back(bf16_compute(func, operand_a, operand_b, operand_c,
                                                    round_mode));
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result %h with no item outstanding", $time, result);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (result !== want.value)
                    begin
                        $display("%0t: result expected %h actual %h", $time, want.value, result);
                        mismatches++;
                    end
                    if (flag_invalid !== want.inv)
                    begin
                        $display("%0t: invalid expected %b actual %b", $time, want.inv,
                                 flag_invalid);
                        mismatches++;
                    end
                    if (flag_overflow !== want.ovf)
                    begin
                        $display("%0t: overflow expected %b actual %b", $time, want.ovf,
                                 flag_overflow);
                        mismatches++;
                    end
                    if (flag_underflow !== want.unf)
                    begin
                        $display("%0t: underflow expected %b actual %b", $time, want.unf,
                                 flag_underflow);
                        mismatches++;
                    end
                    if (flag_inexact !== want.inx)
                    begin
                        $display("%0t: inexact expected %b actual %b", $time, want.inx,
                                 flag_inexact);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

>>> sim/tb_bf16_add_sub_mul_fma_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bf16_add_sub_mul_fma_unit
// Drives directed and random bfloat16 operations through the pipelined unit
// with random idle bursts on both sides; a checker predicts every result.
// ----------------------------------------------------------------------------
module tb_bf16_add_sub_mul_fma_unit;
    import bfu_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = FUNC_ADD;
    logic [15:0] operand_a = 16'd0;
    logic [15:0] operand_b = 16'd0;
    logic [15:0] operand_c = 16'd0;
    logic [1:0]  round_mode = RM_RNE;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] result;
    logic        flag_invalid;
    logic        flag_overflow;
    logic        flag_underflow;
    logic        flag_inexact;

    int mismatches;
    int results_owed;
    int cycle_count = 0;
    // Idle bursts run until the last stretch of the random items.
    bit idling_on = 1'b1;

    bf16_add_sub_mul_fma_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .operand_c      (operand_c),
        .round_mode     (round_mode),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result),
        .flag_invalid   (flag_invalid),
        .flag_overflow  (flag_overflow),
        .flag_underflow (flag_underflow),
        .flag_inexact   (flag_inexact)
    );

    bf16_fma_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .operand_c      (operand_c),
        .round_mode     (round_mode),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result),
        .flag_invalid   (flag_invalid),
        .flag_overflow  (flag_overflow),
        .flag_underflow (flag_underflow),
        .flag_inexact   (flag_inexact),
        .mismatches     (mismatches),
        .results_owed   (results_owed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The watchdog ends a hung run; it allows for every item and every stall many times over.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one item and holds it until the unit takes it. Before the item a random
    // idle burst may drop valid, so gaps land on every stage of the pipeline.
    task automatic offer_item(logic [1:0] op, logic [15:0] a, logic [15:0] b,
                              logic [15:0] c, logic [1:0] mode);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        operand_a  <= a;
        operand_b  <= b;
        operand_c  <= c;
        round_mode <= mode;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Operand drawn with weight on the special encodings and the exponent extremes.
    function automatic logic [15:0] random_operand();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 11))
            0: v[14:0] = 15'd0;
            1: v[14:0] = 15'h7F80;
            2:
            begin
                v[14:7] = 8'hFF;
                if (v[6:0] == 7'd0)
                    v[0] = 1'b1;
            end
            3: v[14:7] = 8'h00;
            4: v[14:7] = 8'($urandom_range(1, 3));
            5: v[14:7] = 8'($urandom_range(250, 254));
            default: ;
        endcase
        return v;
    endfunction

    // Biased exponent clamped into the finite range.
    function automatic logic [7:0] clamp_exp(int e);
        if (e < 0)
            return 8'd0;
        if (e > 254)
            return 8'd254;
        return 8'(e);
    endfunction

    // The receiver stalls in random bursts, and once holds off for a long stretch
    // while the sender keeps offering, so the pipeline fills and stalls its input.
    initial
    begin
        int held;
        bit long_done;
        long_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (!long_done && cycle_count > 400)
            begin
                long_done = 1;
                out_stall <= 1'b1;
                held = 0;
                while (held < LONG_HOLD)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [1:0]  op, mode;
        logic [15:0] a, b, c;
        int          ea, eb;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: signed zeros under RNE, RDN and RUP, infinities, NaN ordering, and the
        // precedence of infinity times zero over a NaN addend.
        offer_item(FUNC_ADD, 16'h0000, 16'h8000, 16'h0000, RM_RNE);
        offer_item(FUNC_ADD, 16'h0000, 16'h8000, 16'h0000, RM_RDN);
        offer_item(FUNC_SUB, 16'h8000, 16'h0000, 16'h0000, RM_RUP);
        offer_item(FUNC_SUB, 16'h3F80, 16'h3F80, 16'h0000, RM_RDN);
        offer_item(FUNC_ADD, 16'h7F80, 16'hFF80, 16'h0000, RM_RNE);
        offer_item(FUNC_SUB, 16'h7F80, 16'h7F80, 16'h0000, RM_RTZ);
        offer_item(FUNC_MUL, 16'h7F80, 16'h0000, 16'h0000, RM_RNE);
        offer_item(FUNC_FMA, 16'h8000, 16'hFF80, 16'h7F81, RM_RNE);
        offer_item(FUNC_FMA, 16'h7F80, 16'h3F80, 16'hFF80, RM_RUP);
        offer_item(FUNC_FMA, 16'h3F80, 16'h3F80, 16'hFF80, RM_RNE);
        offer_item(FUNC_SUB, 16'h3F80, 16'hFF81, 16'h0000, RM_RNE);
        offer_item(FUNC_FMA, 16'h7FC1, 16'h7F81, 16'hFF82, RM_RTZ);
        offer_item(FUNC_MUL, 16'h0000, 16'h8000, 16'h7F80, RM_RNE);
        // Overflow under each rounding mode and both signs.
        offer_item(FUNC_ADD, 16'h7F7F, 16'h7F7F, 16'h0000, RM_RNE);
        offer_item(FUNC_ADD, 16'h7F7F, 16'h7F7F, 16'h0000, RM_RTZ);
        offer_item(FUNC_MUL, 16'hFF7F, 16'h4000, 16'h0000, RM_RUP);
        offer_item(FUNC_MUL, 16'hFF7F, 16'h4000, 16'h0000, RM_RDN);
        // Subnormals: underflow to zero, rounding up to the smallest normal, exact tiny.
        offer_item(FUNC_MUL, 16'h0001, 16'h3F00, 16'h0000, RM_RNE);
        offer_item(FUNC_MUL, 16'h0001, 16'h0001, 16'h0000, RM_RUP);
        offer_item(FUNC_MUL, 16'h007F, 16'h3F81, 16'h0000, RM_RUP);
        offer_item(FUNC_ADD, 16'h0001, 16'h007F, 16'h0000, RM_RNE);
        offer_item(FUNC_FMA, 16'h3F81, 16'h3F81, 16'hBF82, RM_RNE);
        offer_item(FUNC_FMA, 16'hFFFF, 16'hFFFF, 16'hFFFF, RM_RUP);

        // Random: mostly finite data, with cancelling pairs for add and an addend
        // near the product for fma so that the exact sum loses many bits.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - 200)
                idling_on = 1'b0;
            op   = 2'($urandom_range(0, 3));
            mode = 2'($urandom_range(0, 3));
            a = random_operand();
            b = random_operand();
            c = random_operand();
            if ($urandom_range(0, 3) == 0)
            begin
                if (op == FUNC_ADD || op == FUNC_SUB)
                begin
                    b = a ^ 16'($urandom_range(0, 7));
                    b[15] = (op == FUNC_ADD) ? !a[15] : a[15];
                end
                else
                begin
                    ea = int'(a[14:7]);
                    eb = int'(b[14:7]);
                    c[14:7] = clamp_exp(ea + eb - 127 + $urandom_range(0, 6) - 3);
                    c[15] = !(a[15] ^ b[15]);
                end
            end
            offer_item(op, a, b, c, mode);
        end
        in_valid <= 1'b0;

        while (results_owed != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> bf16_add_sub_mul_fma_unit.f
+incdir+rtl
rtl/bfu_pkg.sv
rtl/bfu_round.sv
rtl/bf16_add_sub_mul_fma_unit.sv
sim/bf16_fma_checker.sv
sim/tb_bf16_add_sub_mul_fma_unit.sv
